// File: hdl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// Byte packet deframer package
// Sizes, codes, state encodings and the result word layout used by the
// deframer.
// ----------------------------------------------------------------------------
package bpd_pkg;

    // Display and payload geometry.
    localparam int DISPLAY_WIDTH = 128;
    localparam int DISPLAY_PAGES = 8;
    localparam int PAYLOAD_DEPTH = 256;
    localparam int DISPLAY_DEPTH = 1024;

    localparam int DISP_AW = 10;
    localparam int PAY_AW  = $clog2(PAYLOAD_DEPTH);
    localparam int PAGE_W  = (DISPLAY_PAGES > 1) ? $clog2(DISPLAY_PAGES) : 1;
    localparam int IDX_W   = $clog2(DISPLAY_WIDTH + 1);
    localparam int COPY_AW = (DISPLAY_PAGES * DISPLAY_WIDTH > 1) ?
                             $clog2(DISPLAY_PAGES * DISPLAY_WIDTH) : 1;

    // Port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 88;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARKER   = 3'd0,
        REG_END_MARKER     = 3'd1,
        REG_LINK_REQUEST   = 3'd2,
        REG_LINK_OK        = 3'd3,
        REG_IMAGE_REQUEST  = 3'd4,
        REG_IMAGE_OK       = 3'd5,
        REG_READ_REQUEST   = 3'd6,
        REG_READ_OK        = 3'd7
    } cfg_reg_t;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_PACKET_DONE = 3'd0,
        EV_BAD_START1  = 3'd1,
        EV_BAD_START2  = 3'd2,
        EV_BAD_END1    = 3'd3,
        EV_BAD_END2    = 3'd4,
        EV_READ_DATA   = 3'd5
    } event_t;

    // Request codes reported with a finished packet.
    typedef enum logic [2:0] {
        REQ_NONE       = 3'd0,
        REQ_LINK       = 3'd1,
        REQ_LINK_OK    = 3'd2,
        REQ_IMAGE_DONE = 3'd3,
        REQ_IMAGE_OK   = 3'd4,
        REQ_READ       = 3'd5,
        REQ_READ_OK    = 3'd6
    } req_code_t;

    // Error counter selection.
    typedef enum logic [1:0] {
        ERR_START1 = 2'd0,
        ERR_START2 = 2'd1,
        ERR_END1   = 2'd2,
        ERR_END2   = 2'd3
    } err_kind_t;

    // Framer phase, one-hot.
    typedef enum logic [7:0] {
        PH_START1 = 8'b0000_0001,
        PH_START2 = 8'b0000_0010,
        PH_TYPE   = 8'b0000_0100,
        PH_SEQ    = 8'b0000_1000,
        PH_LEN    = 8'b0001_0000,
        PH_DATA   = 8'b0010_0000,
        PH_END1   = 8'b0100_0000,
        PH_END2   = 8'b1000_0000
    } phase_t;

    // Sequencer state, one-hot.
    typedef enum logic [3:0] {
        CT_CLEAR = 4'b0001,
        CT_IDLE  = 4'b0010,
        CT_READ  = 4'b0100,
        CT_COPY  = 4'b1000
    } ctrl_t;

    // Result word, packet_type in the lowest bits.
    typedef struct packed {
        logic        pad;
        logic [7:0]  read_data;
        logic [15:0] error_count;
        logic [31:0] image_sum;
        logic        image_complete;
        logic [2:0]  page_index;
        logic [2:0]  request_code;
        logic [7:0]  length;
        logic [7:0]  sequence_res;
        logic [7:0]  packet_type;
    } out_item_t;

endpackage

// File: hdl/byte_packet_deframer.sv
// ----------------------------------------------------------------------------
// Byte packet deframer
// Hunts for framed packets in a received byte stream, keeps payload and
// display stores in RAM, and reports packets, framing errors and reads.
// ----------------------------------------------------------------------------
// Link bytes are taken one per cycle while s_tready is high; a framing error or
// non-image packet result is in the output register the cycle after the byte
// that causes it. A read item passes through the READ state (RAM read). The end
// of an image packet pauses input while the payload RAM is copied into the
// display RAM one byte a cycle. After reset a clearing pass zeroes both RAMs;
// no input is taken until it ends. Configuration writes are taken at any time.
module byte_packet_deframer (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wen,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bpd_pkg::S_TDATA_W-1:0]    s_tdata,  // rx_byte[7:0], read_address[17:8]
    input  logic                             s_tuser,  // kind
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // packet_type[7:0], sequence_res[15:8], length[23:16], request_code[26:24],
    // page_index[29:27], image_complete[30], image_sum[62:31],
    // error_count[78:63], read_data[86:79]
    output logic [bpd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [2:0]                       m_tuser   // event_res
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bpd_pkg::ctrl_t                    ctrl_reg, ctrl_next;
    bpd_pkg::phase_t                   phase_reg, phase_next;
    logic [7:0]                        pay_cnt_reg, pay_cnt_next;
    logic [7:0]                        held_type_reg, held_type_next;
    logic [7:0]                        held_seq_reg, held_seq_next;
    logic [7:0]                        held_len_reg, held_len_next;
    logic [bpd_pkg::PAGE_W-1:0]        page_cnt_reg, page_cnt_next;
    logic [31:0]                       sum_reg, sum_next;
    logic [15:0]                       err_cnt_reg [4];
    logic [15:0]                       err_cnt_next [4];
    logic [bpd_pkg::DISP_AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [bpd_pkg::IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [bpd_pkg::IDX_W-1:0]         wr_idx_reg, wr_idx_next;
    logic                              wv_reg, wv_next;
    logic                              wr_inr_reg, wr_inr_next;
    logic [bpd_pkg::COPY_AW-1:0]       base_reg, base_next;
    logic                              out_valid_reg, out_valid_next;
    bpd_pkg::event_t                   out_event_reg, out_event_next;
    bpd_pkg::out_item_t                out_item_reg, out_item_next;

    logic [15:0]                       start_marker_reg;
    logic [15:0]                       end_marker_reg;
    logic [7:0]                        code_link_req_reg;
    logic [7:0]                        code_link_ok_reg;
    logic [7:0]                        code_image_req_reg;
    logic [7:0]                        code_image_ok_reg;
    logic [7:0]                        code_read_req_reg;
    logic [7:0]                        code_read_ok_reg;

    // RAM ports.
    logic                              disp_we;
    logic [bpd_pkg::DISP_AW-1:0]       disp_waddr;
    logic [7:0]                        disp_wdata;
    logic [7:0]                        disp_rdata;
    logic                              pay_we;
    logic [bpd_pkg::PAY_AW-1:0]        pay_waddr;
    logic [7:0]                        pay_wdata;
    logic [bpd_pkg::PAY_AW-1:0]        pay_raddr;
    logic [7:0]                        pay_rdata;

    // Input word fields.
    logic                              in_fire;
    logic [7:0]                        in_byte;
    logic [bpd_pkg::DISP_AW-1:0]       in_addr;

    // Packet type decode.
    bpd_pkg::req_code_t                type_code;
    logic                              type_is_image;

    assign in_byte  = s_tdata[7:0];
    assign in_addr  = s_tdata[17:8];
    assign s_tready = (ctrl_reg == bpd_pkg::CT_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;
    assign m_tuser  = out_event_reg;

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    bpd_ram #(
        .WIDTH (8),
        .DEPTH (bpd_pkg::DISPLAY_DEPTH)
    ) u_display_ram (
        .clk     (clk),
        .wr_en   (disp_we),
        .wr_addr (disp_waddr),
        .wr_data (disp_wdata),
        .rd_addr (in_addr),
        .rd_data (disp_rdata)
    );

    bpd_ram #(
        .WIDTH (8),
        .DEPTH (bpd_pkg::PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (pay_we),
        .wr_addr (pay_waddr),
        .wr_data (pay_wdata),
        .rd_addr (pay_raddr),
        .rd_data (pay_rdata)
    );

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg   <= '0;
            end_marker_reg     <= '0;
            code_link_req_reg  <= '0;
            code_link_ok_reg   <= '0;
            code_image_req_reg <= '0;
            code_image_ok_reg  <= '0;
            code_read_req_reg  <= '0;
            code_read_ok_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                bpd_pkg::REG_START_MARKER:  start_marker_reg   <= cfg_data;
                bpd_pkg::REG_END_MARKER:    end_marker_reg     <= cfg_data;
                bpd_pkg::REG_LINK_REQUEST:  code_link_req_reg  <= cfg_data[7:0];
                bpd_pkg::REG_LINK_OK:       code_link_ok_reg   <= cfg_data[7:0];
                bpd_pkg::REG_IMAGE_REQUEST: code_image_req_reg <= cfg_data[7:0];
                bpd_pkg::REG_IMAGE_OK:      code_image_ok_reg  <= cfg_data[7:0];
                bpd_pkg::REG_READ_REQUEST:  code_read_req_reg  <= cfg_data[7:0];
                bpd_pkg::REG_READ_OK:       code_read_ok_reg   <= cfg_data[7:0];
                default:                    start_marker_reg   <= start_marker_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Packet type decode, first match wins
    // ------------------------------------------------------------------
    always_comb
    begin
        type_code     = bpd_pkg::REQ_NONE;
        type_is_image = 1'b0;
        if (held_type_reg == code_link_req_reg)
        begin
            type_code = bpd_pkg::REQ_LINK;
        end
        else if (held_type_reg == code_link_ok_reg)
        begin
            type_code = bpd_pkg::REQ_LINK_OK;
        end
        else if (held_type_reg == code_image_req_reg)
        begin
            type_is_image = 1'b1;
        end
        else if (held_type_reg == code_image_ok_reg)
        begin
            type_code = bpd_pkg::REQ_IMAGE_OK;
        end
        else if (held_type_reg == code_read_req_reg)
        begin
            type_code = bpd_pkg::REQ_READ;
        end
        else if (held_type_reg == code_read_ok_reg)
        begin
            type_code = bpd_pkg::REQ_READ_OK;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, framer and copy engine
    // ------------------------------------------------------------------
    always_comb
    begin
        logic                            err_fire;
        bpd_pkg::err_kind_t              err_sel;
        logic                            done_fire;
        logic [15:0]                     err_bumped;
        logic [7:0]                      cnt_inc;
        logic [7:0]                      copy_byte;
        logic [bpd_pkg::COPY_AW-1:0]     copy_addr;
        logic [bpd_pkg::PAGE_W:0]        page_inc;
        logic                            page_last;
        logic [2:0]                      page_wide;

        err_fire   = 1'b0;
        err_sel    = bpd_pkg::ERR_START1;
        done_fire  = 1'b0;
        err_bumped = '0;
        cnt_inc    = pay_cnt_reg + 8'd1;
        copy_byte  = wr_inr_reg ? pay_rdata : 8'd0;
        copy_addr  = base_reg + bpd_pkg::COPY_AW'(wr_idx_reg);
        page_inc   = {1'b0, page_cnt_reg} + 1'b1;
        page_last  = (page_inc >= (bpd_pkg::PAGE_W + 1)'(bpd_pkg::DISPLAY_PAGES));
        page_wide  = 3'(page_cnt_reg);

        ctrl_next      = ctrl_reg;
        phase_next     = phase_reg;
        pay_cnt_next   = pay_cnt_reg;
        held_type_next = held_type_reg;
        held_seq_next  = held_seq_reg;
        held_len_next  = held_len_reg;
        page_cnt_next  = page_cnt_reg;
        sum_next       = sum_reg;
        err_cnt_next   = err_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        wv_next        = 1'b0;
        wr_inr_next    = wr_inr_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_event_next = out_event_reg;
        out_item_next  = out_item_reg;

        disp_we    = 1'b0;
        disp_waddr = '0;
        disp_wdata = '0;
        pay_we     = 1'b0;
        pay_waddr  = '0;
        pay_wdata  = '0;
        pay_raddr  = bpd_pkg::PAY_AW'(rd_idx_reg);

        case (ctrl_reg)
            // Zero both stores after reset, one entry a cycle.
            bpd_pkg::CT_CLEAR:
            begin
                disp_we      = 1'b1;
                disp_waddr   = clr_cnt_reg;
                pay_we       = (clr_cnt_reg < bpd_pkg::DISP_AW'(bpd_pkg::PAYLOAD_DEPTH))
                               || (bpd_pkg::PAYLOAD_DEPTH >= bpd_pkg::DISPLAY_DEPTH);
                pay_waddr    = bpd_pkg::PAY_AW'(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == bpd_pkg::DISP_AW'(bpd_pkg::DISPLAY_DEPTH - 1))
                begin
                    ctrl_next = bpd_pkg::CT_IDLE;
                end
            end

            // Take link bytes and read items.
            bpd_pkg::CT_IDLE:
            begin
                if (in_fire && s_tuser)
                begin
                    ctrl_next = bpd_pkg::CT_READ;
                end
                else if (in_fire)
                begin
                    case (phase_reg)
                        bpd_pkg::PH_START1:
                        begin
                            if (in_byte == start_marker_reg[15:8])
                            begin
                                phase_next = bpd_pkg::PH_START2;
                            end
                            else
                            begin
                                err_fire = 1'b1;
                                err_sel  = bpd_pkg::ERR_START1;
                            end
                        end
                        bpd_pkg::PH_START2:
                        begin
                            if (in_byte == start_marker_reg[7:0])
                            begin
                                phase_next = bpd_pkg::PH_TYPE;
                            end
                            else
                            begin
                                err_fire = 1'b1;
                                err_sel  = bpd_pkg::ERR_START2;
                            end
                        end
                        bpd_pkg::PH_TYPE:
                        begin
                            held_type_next = in_byte;
                            phase_next     = bpd_pkg::PH_SEQ;
                        end
                        bpd_pkg::PH_SEQ:
                        begin
                            held_seq_next = in_byte;
                            phase_next    = bpd_pkg::PH_LEN;
                        end
                        bpd_pkg::PH_LEN:
                        begin
                            held_len_next = in_byte;
                            pay_cnt_next  = '0;
                            phase_next    = (in_byte == 8'd0) ? bpd_pkg::PH_END1
                                                              : bpd_pkg::PH_DATA;
                        end
                        bpd_pkg::PH_DATA:
                        begin
                            // Bytes beyond the payload store are dropped.
                            pay_we    = ({1'b0, pay_cnt_reg} <
                                         9'(bpd_pkg::PAYLOAD_DEPTH));
                            pay_waddr = bpd_pkg::PAY_AW'(pay_cnt_reg);
                            pay_wdata = in_byte;
                            if (cnt_inc == held_len_reg)
                            begin
                                pay_cnt_next = '0;
                                phase_next   = bpd_pkg::PH_END1;
                            end
                            else
                            begin
                                pay_cnt_next = cnt_inc;
                            end
                        end
                        bpd_pkg::PH_END1:
                        begin
                            if (in_byte == end_marker_reg[15:8])
                            begin
                                phase_next = bpd_pkg::PH_END2;
                            end
                            else
                            begin
                                err_fire = 1'b1;
                                err_sel  = bpd_pkg::ERR_END1;
                            end
                        end
                        bpd_pkg::PH_END2:
                        begin
                            if (in_byte == end_marker_reg[7:0])
                            begin
                                done_fire    = 1'b1;
                                phase_next   = bpd_pkg::PH_START1;
                                pay_cnt_next = '0;
                            end
                            else
                            begin
                                err_fire = 1'b1;
                                err_sel  = bpd_pkg::ERR_END2;
                            end
                        end
                        default:
                        begin
                            phase_next = bpd_pkg::PH_START1;
                        end
                    endcase
                end

                // Framing error: bump the saturating counter and resync.
                if (err_fire)
                begin
                    err_bumped = (err_cnt_reg[err_sel] == 16'hFFFF) ?
                                 err_cnt_reg[err_sel] : err_cnt_reg[err_sel] + 16'd1;
                    err_cnt_next[err_sel]     = err_bumped;
                    phase_next                = bpd_pkg::PH_START1;
                    pay_cnt_next              = '0;
                    out_valid_next            = 1'b1;
                    out_item_next             = '0;
                    out_item_next.error_count = err_bumped;
                    case (err_sel)
                        bpd_pkg::ERR_START1: out_event_next = bpd_pkg::EV_BAD_START1;
                        bpd_pkg::ERR_START2: out_event_next = bpd_pkg::EV_BAD_START2;
                        bpd_pkg::ERR_END1:   out_event_next = bpd_pkg::EV_BAD_END1;
                        bpd_pkg::ERR_END2:   out_event_next = bpd_pkg::EV_BAD_END2;
                        default:             out_event_next = bpd_pkg::EV_BAD_START1;
                    endcase
                end

                // Packet end: image pages go to the copy engine first.
                if (done_fire && type_is_image)
                begin
                    ctrl_next   = bpd_pkg::CT_COPY;
                    rd_idx_next = '0;
                    base_next   = bpd_pkg::COPY_AW'(page_cnt_reg * bpd_pkg::DISPLAY_WIDTH);
                end
                else if (done_fire)
                begin
                    out_valid_next             = 1'b1;
                    out_event_next             = bpd_pkg::EV_PACKET_DONE;
                    out_item_next              = '0;
                    out_item_next.packet_type  = held_type_reg;
                    out_item_next.sequence_res = held_seq_reg;
                    out_item_next.length       = held_len_reg;
                    out_item_next.request_code = type_code;
                    out_item_next.image_sum    = sum_reg;
                end
            end

            // Display byte arrives in the cycle after the read was taken.
            bpd_pkg::CT_READ:
            begin
                out_valid_next          = 1'b1;
                out_event_next          = bpd_pkg::EV_READ_DATA;
                out_item_next           = '0;
                out_item_next.read_data = disp_rdata;
                ctrl_next               = bpd_pkg::CT_IDLE;
            end

            // Copy one payload byte a cycle: read, then write and add.
            bpd_pkg::CT_COPY:
            begin
                if (rd_idx_reg < bpd_pkg::IDX_W'(bpd_pkg::DISPLAY_WIDTH))
                begin
                    wv_next     = 1'b1;
                    wr_idx_next = rd_idx_reg;
                    wr_inr_next = ((bpd_pkg::IDX_W + 1)'(rd_idx_reg) <
                                   (bpd_pkg::IDX_W + 1)'(bpd_pkg::PAYLOAD_DEPTH))
                                  || (bpd_pkg::PAYLOAD_DEPTH >= bpd_pkg::DISPLAY_WIDTH);
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (wv_reg)
                begin
                    disp_we    = ((bpd_pkg::COPY_AW + 1)'(copy_addr) <
                                  (bpd_pkg::COPY_AW + 1)'(bpd_pkg::DISPLAY_DEPTH))
                                 || (bpd_pkg::DISPLAY_PAGES * bpd_pkg::DISPLAY_WIDTH
                                     <= bpd_pkg::DISPLAY_DEPTH);
                    disp_waddr = bpd_pkg::DISP_AW'(copy_addr);
                    disp_wdata = copy_byte;
                    sum_next   = sum_reg + 32'(copy_byte);
                    if (wr_idx_reg == bpd_pkg::IDX_W'(bpd_pkg::DISPLAY_WIDTH - 1))
                    begin
                        ctrl_next                    = bpd_pkg::CT_IDLE;
                        page_cnt_next                = page_last ? '0
                                                       : page_inc[bpd_pkg::PAGE_W-1:0];
                        out_valid_next               = 1'b1;
                        out_event_next               = bpd_pkg::EV_PACKET_DONE;
                        out_item_next                = '0;
                        out_item_next.packet_type    = held_type_reg;
                        out_item_next.sequence_res   = held_seq_reg;
                        out_item_next.length         = held_len_reg;
                        out_item_next.request_code   = page_last ? bpd_pkg::REQ_IMAGE_DONE
                                                                 : bpd_pkg::REQ_NONE;
                        out_item_next.page_index     = page_wide;
                        out_item_next.image_complete = page_last;
                        out_item_next.image_sum      = sum_reg + 32'(copy_byte);
                    end
                end
            end

            default:
            begin
                ctrl_next = bpd_pkg::CT_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= bpd_pkg::CT_CLEAR;
            phase_reg     <= bpd_pkg::PH_START1;
            pay_cnt_reg   <= '0;
            held_type_reg <= '0;
            held_seq_reg  <= '0;
            held_len_reg  <= '0;
            page_cnt_reg  <= '0;
            sum_reg       <= '0;
            err_cnt_reg   <= '{default: '0};
            clr_cnt_reg   <= '0;
            rd_idx_reg    <= '0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg      <= ctrl_next;
            phase_reg     <= phase_next;
            pay_cnt_reg   <= pay_cnt_next;
            held_type_reg <= held_type_next;
            held_seq_reg  <= held_seq_next;
            held_len_reg  <= held_len_next;
            page_cnt_reg  <= page_cnt_next;
            sum_reg       <= sum_next;
            err_cnt_reg   <= err_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            wv_reg        <= wv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Copy pipeline and result payload.
    always_ff @(posedge clk)
    begin
        wr_idx_reg    <= wr_idx_next;
        wr_inr_reg    <= wr_inr_next;
        base_reg      <= base_next;
        out_event_reg <= out_event_next;
        out_item_reg  <= out_item_next;
    end

endmodule

// File: hdl/bpd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
